/* hw/rtl/sha_pkg.sv */
// SHA-256 block compression: shared constants, types and round functions.
// Used by the channel interfaces and every module of the block.
package sha_pkg;

   localparam int WORD_W = 32;

   localparam logic [3:0] LAST_MSG_IDX   = 4'hF;
   localparam logic [5:0] LAST_ROUND_IDX = 6'd63;
   localparam logic [2:0] LAST_CHAIN_IDX = 3'd7;

   localparam logic [WORD_W-1:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [WORD_W-1:0] INIT_HASH [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
   };

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_ADD   = 4'b0100,
      ST_SEND  = 4'b1000
   } state_type;

   typedef struct packed {
      logic       load_word;
      logic       reload_chain;
      logic       init_vars;
      logic       round_en;
      logic [5:0] round_idx;
      logic       add_en;
      logic [2:0] chain_idx;
   } ctrl_type;

   function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

/* hw/rtl/sha_ifs.sv */
// Valid/ready channel interfaces for message words and digest words.
// Depends on sha_pkg for the word width.
interface sha_req_if import sha_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] msg_word;
   logic              new_message;

   modport source (output valid, output msg_word, output new_message, input ready);
   modport sink (input valid, input msg_word, input new_message, output ready);
endinterface

interface sha_rsp_if import sha_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] digest_word;
   logic [2:0]        digest_index;
   logic              last_word;

   modport source (output valid, output digest_word, output digest_index,
                   output last_word, input ready);
   modport sink (input valid, input digest_word, input digest_index,
                 input last_word, output ready);
endinterface

/* hw/rtl/sha_sched.sv */
// Message schedule: sixteen-word shift line, expanded one word per round.
// Depends on sha_pkg for the small sigma functions and control struct.
module sha_sched import sha_pkg::*; (
   input  logic              clock,
   input  ctrl_type          ctrl,
   input  logic [WORD_W-1:0] word_in,
   output logic [WORD_W-1:0] sched_word
);

   logic [WORD_W-1:0] w_ff [16];
   logic [WORD_W-1:0] w_new;

   assign w_new = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];
   assign sched_word = w_ff[0];

   always_ff @(posedge clock) begin
      if (ctrl.load_word || ctrl.round_en) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= ctrl.load_word ? word_in : w_new;
      end
   end

endmodule

/* hw/rtl/sha_core.sv */
// Round datapath: chaining value, working variables, shared round unit
// and the serial add-back of the working variables. Depends on sha_pkg.
module sha_core import sha_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctrl_type          ctrl,
   input  logic [WORD_W-1:0] sched_word,
   output logic [WORD_W-1:0] sum_word
);

   logic [WORD_W-1:0] chain_ff [8];
   logic [WORD_W-1:0] var_ff [8];
   logic [WORD_W-1:0] t1;
   logic [WORD_W-1:0] t2;
   logic [WORD_W-1:0] ch;
   logic [WORD_W-1:0] maj;

   assign ch  = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]);
   assign t1  = var_ff[7] + big_sigma1(var_ff[4]) + ch + ROUND_K[ctrl.round_idx] + sched_word;
   assign t2  = big_sigma0(var_ff[0]) + maj;
   assign sum_word = chain_ff[ctrl.chain_idx] + var_ff[ctrl.chain_idx];

   always_ff @(posedge clock) begin
      if (reset || ctrl.reload_chain) begin
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= INIT_HASH[i];
         end
      end else if (ctrl.add_en) begin
         chain_ff[ctrl.chain_idx] <= sum_word;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.init_vars) begin
         var_ff <= chain_ff;
      end else if (ctrl.round_en) begin
         var_ff[7] <= var_ff[6];
         var_ff[6] <= var_ff[5];
         var_ff[5] <= var_ff[4];
         var_ff[4] <= var_ff[3] + t1;
         var_ff[3] <= var_ff[2];
         var_ff[2] <= var_ff[1];
         var_ff[1] <= var_ff[0];
         var_ff[0] <= t1 + t2;
      end
   end

endmodule

/* hw/rtl/sha_ctrl.sv */
// Sequencer: word count, round counter and digest word emission.
// Depends on sha_pkg for the state encoding and control struct.
module sha_ctrl import sha_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   input  logic     req_new,
   input  logic     rsp_ready,
   output logic     req_ready,
   output logic     rsp_valid,
   output ctrl_type ctrl
);

   state_type  state_ff, state_in;
   logic [3:0] count_ff, count_in;
   logic [5:0] round_ff, round_in;
   logic [2:0] idx_ff, idx_in;
   logic [3:0] count_base;
   logic       req_accept;

   assign req_ready  = (state_ff == ST_LOAD);
   assign rsp_valid  = (state_ff == ST_SEND);
   assign req_accept = req_valid && req_ready;
   assign count_base = req_new ? 4'd0 : count_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      ctrl     = '0;
      ctrl.round_idx = round_ff;
      ctrl.chain_idx = idx_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_accept) begin
               ctrl.load_word    = 1'b1;
               ctrl.reload_chain = req_new;
               count_in = count_base + 4'd1;
               if (count_base == LAST_MSG_IDX) begin
                  ctrl.init_vars = 1'b1;
                  round_in = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            ctrl.round_en = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND_IDX) begin
               idx_in   = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            ctrl.add_en = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_ready) begin
               idx_in   = idx_ff + 3'd1;
               state_in = (idx_ff == LAST_CHAIN_IDX) ? ST_LOAD : ST_ADD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

/* hw/rtl/sha256_block_compress.sv */
// SHA-256 block compression, one 32-bit message word per item.
// Words are taken one per cycle while valid is held; after the 16th word
// the block runs the rounds on the single round unit, then emits eight
// digest items, each via an add and a send state, and takes no new word
// until the last is accepted. Synchronous reset loads the initial hash values.
module sha256_block_compress import sha_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sha_req_if.sink    req_if,
   sha_rsp_if.source  rsp_if
);

   ctrl_type          ctrl;
   logic [WORD_W-1:0] sched_word;
   logic [WORD_W-1:0] sum_word;
   logic [WORD_W-1:0] digest_ff;

   sha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_new   (req_if.new_message),
      .rsp_ready (rsp_if.ready),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .ctrl      (ctrl)
   );

   sha_sched u_sched (
      .clock      (clock),
      .ctrl       (ctrl),
      .word_in    (req_if.msg_word),
      .sched_word (sched_word)
   );

   sha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sched_word (sched_word),
      .sum_word   (sum_word)
   );

   always_ff @(posedge clock) begin
      if (ctrl.add_en) begin
         digest_ff <= sum_word;
      end
   end

   assign rsp_if.digest_word  = digest_ff;
   assign rsp_if.digest_index = ctrl.chain_idx;
   assign rsp_if.last_word    = (ctrl.chain_idx == LAST_CHAIN_IDX);

endmodule

/* hw/rtl/sha_checker.sv */
// Port-level checks for sha256_block_compress, attached by bind.
// Depends on sha_pkg for constants.
module sha_checker import sha_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [WORD_W-1:0] digest_word,
   input logic [2:0]        digest_index,
   input logic              last_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(digest_word)
         && $stable(digest_index))
      else $error("digest item changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while digest pending");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> last_word == (digest_index == LAST_CHAIN_IDX))
      else $error("last flag does not match index");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last_word |=> ##1
         rsp_valid && digest_index == $past(digest_index, 2) + 3'd1)
      else $error("digest index did not advance");

   a_resume: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && last_word |=> req_ready && !rsp_valid)
      else $error("input not resumed after last digest item");

endmodule

bind sha256_block_compress sha_checker u_sha_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .digest_word  (rsp_if.digest_word),
   .digest_index (rsp_if.digest_index),
   .last_word    (rsp_if.last_word)
);
